@@ src/bps_pkg.sv @@
// Package for the byte pattern search block.
// Holds the configuration register map, fixed field widths and parameter defaults.
// No dependencies.
package bps_pkg;

	localparam int PATTERN_BYTES = 32;
	localparam int PATTERN_IDX_BITS = $clog2(PATTERN_BYTES);
	localparam int WORD_BYTES = 8;
	localparam int LENGTH_BITS = 6;
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS = 64;
	localparam int COUNT_BITS = 16;

	localparam int DEFAULT_MAX_PATTERN = 32;
	localparam int DEFAULT_POSITION_BITS = 16;

	typedef logic [7:0] byte_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PATTERN_LENGTH = 3'd0,
		REG_PATTERN_WORD_0 = 3'd1,
		REG_PATTERN_WORD_1 = 3'd2,
		REG_PATTERN_WORD_2 = 3'd3,
		REG_PATTERN_WORD_3 = 3'd4
	} cfg_reg_t;

endpackage

@@ src/bps_if.sv @@
// Valid/ready stream interfaces of the byte pattern search block.
// bps_text_if carries text bytes in, bps_result_if carries per-byte results out.
// Depends on bps_pkg.
interface bps_text_if;
	import bps_pkg::*;

	logic  valid;
	logic  ready;
	byte_t text_byte;
	logic  last_byte;

	modport source (output valid, text_byte, last_byte, input ready);
	modport sink (input valid, text_byte, last_byte, output ready);
endinterface

interface bps_result_if #(
	parameter int POSITION_BITS = bps_pkg::DEFAULT_POSITION_BITS
);
	import bps_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     match_found;
	logic [POSITION_BITS-1:0] match_start;
	logic                     text_end;
	logic                     any_match;
	logic [POSITION_BITS-1:0] first_start;
	logic [POSITION_BITS-1:0] last_start;
	logic [COUNT_BITS-1:0]    occurrence_count;
	logic                     position_overflow;

	modport source (
		output valid, match_found, match_start, text_end, any_match,
			first_start, last_start, occurrence_count, position_overflow,
		input ready
	);
	modport sink (
		input valid, match_found, match_start, text_end, any_match,
			first_start, last_start, occurrence_count, position_overflow,
		output ready
	);
endinterface

@@ src/byte_pattern_search.sv @@
// Byte pattern search: streaming search of text for a configured pattern of 1 to 32 bytes.
// Top level. Depends on bps_pkg and the interfaces in bps_if.
//
// Each text byte gives exactly one result transaction, telling whether a pattern occurrence
// (overlapping ones included) ends on that byte and where it starts. The result for the byte
// marked last also carries the text summary: any match, first and latest start, a saturating
// occurrence count and a position overflow flag; the per-text state then clears for the next
// text. The block takes one byte per clock cycle while the result output is not stalled. An
// accepted byte is compared against the whole window straight from the input register, and
// its result is then registered in the result register. While a result waits, the input
// register holds its byte, and it can still take one byte if it is empty. The window
// compare is parallel. Write the pattern registers only while no text is in flight.
module byte_pattern_search #(
	parameter int MAX_PATTERN = bps_pkg::DEFAULT_MAX_PATTERN,
	parameter int POSITION_BITS = bps_pkg::DEFAULT_POSITION_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [bps_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [bps_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	bps_text_if.sink                            text,
	bps_result_if.source                        result
);
	import bps_pkg::*;

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);
	localparam int POS_W = POSITION_BITS + 1;
	localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// Configuration registers.
	logic [LENGTH_BITS-1:0]          pattern_length_q;
	byte_t [PATTERN_BYTES-1:0]       pattern_q;

	// Input register.
	logic  valid_s1;
	byte_t byte_s1;
	logic  last_s1;

	// Per-text state.
	byte_t [MAX_PATTERN-1:0]  window_q;
	logic [POS_W-1:0]         pos_q;
	logic                     seen_q;
	logic [POSITION_BITS-1:0] first_q;
	logic [POSITION_BITS-1:0] latest_q;
	logic [COUNT_BITS-1:0]    count_q;
	logic                     ovf_q;

	// Result register.
	logic                     out_valid_q;
	logic                     match_found_q;
	logic [POSITION_BITS-1:0] match_start_q;
	logic                     text_end_q;
	logic                     any_match_q;
	logic [POSITION_BITS-1:0] first_start_q;
	logic [POSITION_BITS-1:0] last_start_q;
	logic [COUNT_BITS-1:0]    occurrence_count_q;
	logic                     position_overflow_q;

	logic                     adv;
	logic [LEN_W-1:0]         len;
	byte_t [MAX_PATTERN-1:0]  win_next;
	byte_t [MAX_PATTERN-1:0]  expected;
	logic                     cmp_ok;
	logic                     hit;
	logic [POS_W-1:0]         start_full;
	logic [POSITION_BITS-1:0] start;
	logic                     seen_next;
	logic [POSITION_BITS-1:0] first_next;
	logic [POSITION_BITS-1:0] latest_next;
	logic [COUNT_BITS-1:0]    count_next;
	logic                     ovf_next;

	assign adv = valid_s1 && (!out_valid_q || result.ready);
	assign text.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= LENGTH_BITS'(1);
			pattern_q <= '0;
		end else if (cfg_write_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[LENGTH_BITS-1:0];
				REG_PATTERN_WORD_0: pattern_q[0*WORD_BYTES +: WORD_BYTES] <= cfg_data;
				REG_PATTERN_WORD_1: pattern_q[1*WORD_BYTES +: WORD_BYTES] <= cfg_data;
				REG_PATTERN_WORD_2: pattern_q[2*WORD_BYTES +: WORD_BYTES] <= cfg_data;
				REG_PATTERN_WORD_3: pattern_q[3*WORD_BYTES +: WORD_BYTES] <= cfg_data;
				default: ;
			endcase
		end
	end

	// A length of zero acts as one, and lengths above the window depth are clipped.
	always_comb begin
		if (pattern_length_q == '0) begin
			len = LEN_W'(1);
		end else if (int'(pattern_length_q) > MAX_PATTERN) begin
			len = LEN_W'(MAX_PATTERN);
		end else begin
			len = LEN_W'(pattern_length_q);
		end
	end

	// Window slot k holds the byte k places back; it must equal pattern byte len-1-k.
	always_comb begin
		logic [LEN_W-1:0] tail;
		win_next[0] = byte_s1;
		for (int k = 1; k < MAX_PATTERN; k++) begin
			win_next[k] = window_q[k-1];
		end
		cmp_ok = 1'b1;
		for (int k = 0; k < MAX_PATTERN; k++) begin
			tail = len - LEN_W'(1) - LEN_W'(k);
			if (int'(tail) < PATTERN_BYTES) begin
				expected[k] = pattern_q[PATTERN_IDX_BITS'(tail)];
			end else begin
				expected[k] = '0;
			end
			if (LEN_W'(k) < len && win_next[k] != expected[k]) begin
				cmp_ok = 1'b0;
			end
		end
	end

	always_comb begin
		hit = cmp_ok && (pos_q >= POS_W'(len) - POS_W'(1));
		start_full = pos_q - (POS_W'(len) - POS_W'(1));
		if (!hit) begin
			start = '0;
		end else if (start_full[POSITION_BITS]) begin
			start = POS_MAX;
		end else begin
			start = start_full[POSITION_BITS-1:0];
		end
		seen_next = seen_q || hit;
		first_next = (hit && !seen_q) ? start : first_q;
		latest_next = hit ? start : latest_q;
		count_next = (hit && count_q != COUNT_MAX) ? count_q + COUNT_BITS'(1) : count_q;
		ovf_next = ovf_q || pos_q[POSITION_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1 <= text.text_byte;
			last_s1 <= text.last_byte;
		end
	end

	// The window is not cleared at the end of a text: a hit needs len bytes of the
	// current text, so older bytes are never compared.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			pos_q <= '0;
			seen_q <= 1'b0;
			first_q <= '0;
			latest_q <= '0;
			count_q <= '0;
			ovf_q <= 1'b0;
		end else if (adv) begin
			window_q <= win_next;
			if (last_s1) begin
				pos_q <= '0;
				seen_q <= 1'b0;
				first_q <= '0;
				latest_q <= '0;
				count_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				pos_q <= pos_q[POSITION_BITS] ? pos_q : pos_q + POS_W'(1);
				seen_q <= seen_next;
				first_q <= first_next;
				latest_q <= latest_next;
				count_q <= count_next;
				ovf_q <= ovf_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			match_found_q <= hit;
			match_start_q <= start;
			text_end_q <= last_s1;
			any_match_q <= last_s1 && seen_next;
			first_start_q <= (last_s1 && seen_next) ? first_next : '0;
			last_start_q <= (last_s1 && seen_next) ? latest_next : '0;
			occurrence_count_q <= last_s1 ? count_next : '0;
			position_overflow_q <= last_s1 && ovf_next;
		end
	end

	assign result.valid = out_valid_q;
	assign result.match_found = match_found_q;
	assign result.match_start = match_start_q;
	assign result.text_end = text_end_q;
	assign result.any_match = any_match_q;
	assign result.first_start = first_start_q;
	assign result.last_start = last_start_q;
	assign result.occurrence_count = occurrence_count_q;
	assign result.position_overflow = position_overflow_q;

endmodule
